/* rtl/smpd_pkg.sv */
package smpd_pkg;

    localparam int NumTypes      = 9;
    localparam int TypeWidth     = 4;
    localparam int CfgIdxWidth   = 3;
    localparam int CfgDataWidth  = 8;
    localparam int MagWidth      = 9;
    localparam int ProdWidth     = 17;
    localparam int QuotWidth     = 17;
    localparam int DivCount      = 17;

    localparam logic [CfgIdxWidth-1:0] CfgMouseType  = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CfgChord      = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CfgThreshold  = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CfgNumerator  = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CfgDenominator = 3'd4;

    localparam logic [TypeWidth-1:0] TypeMs         = 4'd0;
    localparam logic [TypeWidth-1:0] TypeMsc        = 4'd1;
    localparam logic [TypeWidth-1:0] TypeMm         = 4'd2;
    localparam logic [TypeWidth-1:0] TypeLogi       = 4'd3;
    localparam logic [TypeWidth-1:0] TypeLogiman    = 4'd4;
    localparam logic [TypeWidth-1:0] TypeMmhit      = 4'd5;
    localparam logic [TypeWidth-1:0] TypeGlide      = 4'd6;
    localparam logic [TypeWidth-1:0] TypeImserial   = 4'd7;
    localparam logic [TypeWidth-1:0] TypeThinking   = 4'd8;

    typedef struct packed {
        logic [7:0] hd_mask;
        logic [7:0] hd_id;
        logic [7:0] dp_mask;
        logic [7:0] dp_id;
        logic [2:0] len;
        logic [7:0] b4_mask;
        logic [7:0] b4_id;
    } t_proto;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_NEXT,
        ST_DONE,
        ST_OUT
    } t_state;

    function automatic t_proto proto_of(input logic [TypeWidth-1:0] mt);
        t_proto p;
        p = '{8'h40, 8'h40, 8'h40, 8'h00, 3'd3, 8'hDC, 8'h00};
        case (mt)
            TypeMs, TypeLogiman: p = '{8'h40, 8'h40, 8'h40, 8'h00, 3'd3, 8'hDC, 8'h00};
            TypeMsc:             p = '{8'hF8, 8'h80, 8'h00, 8'h00, 3'd5, 8'h00, 8'hFF};
            TypeMm, TypeLogi, TypeMmhit:
                                 p = '{8'hE0, 8'h80, 8'h80, 8'h00, 3'd3, 8'h00, 8'hFF};
            TypeGlide, TypeThinking:
                                 p = '{8'h40, 8'h40, 8'h40, 8'h00, 3'd3, 8'hCC, 8'h00};
            TypeImserial:        p = '{8'h40, 8'h40, 8'h40, 8'h00, 3'd3, 8'hC0, 8'h00};
            default:             p = '{8'h40, 8'h40, 8'h40, 8'h00, 3'd3, 8'hDC, 8'h00};
        endcase
        return p;
    endfunction

endpackage

/* rtl/smpd_rx_if.sv */
interface smpd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/smpd_res_if.sv */
interface smpd_res_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic signed [3:0]  wheel;
    logic [6:0]         button_state;
    logic [2:0]         button_changed;
    modport source (output valid, output move_x, output move_y, output wheel,
                    output button_state, output button_changed, input ready);
    modport sink (input valid, input move_x, input move_y, input wheel,
                  input button_state, input button_changed, output ready);
endinterface

/* rtl/serial_mouse_packet_decoder_top.sv */
// Channel   Dir  Payload                                         Handshake
// rx        in   rx_byte[7:0]                                    valid/ready
// res       out  move_x, move_y, wheel, button_state, changed    valid/ready
// cfg       in   i_cfg_idx[2:0], i_cfg_data[7:0]                 i_cfg_we
//
// A byte that ends a packet passes, after its accept, through a decode state,
// then per axis a load state, 17 restoring steps and a saturation step on a
// shared subtract-and-shift unit, then an output state that raises the beat.
// A trailing fourth byte skips the decode state. Other bytes are stored or
// dropped while the block stays idle. Reset is synchronous; no clearing pass.
// The next byte is taken only after the result beat has left the output
// register, so a stalled sink holds the block.
module serial_mouse_packet_decoder_top
    import smpd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [CfgDataWidth-1:0] i_cfg_data,
    smpd_rx_if.sink                 rx,
    smpd_res_if.source              res
);

    logic [TypeWidth-1:0] r_type;
    logic                 r_chord;
    logic [7:0]           r_thr, r_num, r_den;
    logic [2:0]           r_fill, n_fill;
    logic [7:0]           r_pkt [5];
    logic [6:0]           r_last, n_last;
    t_state               r_state, n_state;

    // per-result working registers
    logic signed [MagWidth:0] r_dx, r_dy, n_dx, n_dy;
    logic signed [3:0]    r_dz, n_dz;
    logic [6:0]           r_btn, n_btn;
    logic                 r_axis, n_axis;
    logic [4:0]           r_cnt, n_cnt;
    logic [ProdWidth-1:0] r_rem_src, n_rem_src;
    logic [8:0]           r_rem, n_rem;
    logic [QuotWidth-1:0] r_quo, n_quo;
    logic signed [15:0]   r_mx, r_my, n_mx, n_my;
    logic [2:0]           r_chg, n_chg;
    logic                 r_ovalid, n_ovalid;

    logic       accept;
    logic [7:0] b;
    t_proto     p;
    logic       wr_en;
    logic [2:0] wr_idx;

    assign accept = rx.valid && rx.ready;
    assign b      = rx.rx_byte;
    assign p      = proto_of(r_type);
    assign rx.ready = (r_state == ST_IDLE) && !r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type  <= '0;
            r_chord <= 1'b0;
            r_thr   <= 8'd4;
            r_num   <= 8'd2;
            r_den   <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgMouseType:   r_type  <= i_cfg_data[TypeWidth-1:0];
                CfgChord:       r_chord <= i_cfg_data[0];
                CfgThreshold:   r_thr   <= i_cfg_data;
                CfgNumerator:   r_num   <= i_cfg_data;
                CfgDenominator: r_den   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pkt[wr_idx] <= b;
        end
    end

    function automatic logic signed [MagWidth:0] sx8(input logic [7:0] v);
        return {{(MagWidth-7){v[7]}}, v};
    endfunction

    // one axis division: magnitude, threshold test, product, trial step, saturation
    logic signed [MagWidth:0] cur_d;
    logic [MagWidth:0]        cur_m;
    logic                     cur_acc;
    logic [MagWidth:0]        m_minus_t;
    logic [ProdWidth-1:0]     prod;
    logic [7:0]               den_eff;
    logic [8:0]               trial;
    logic [QuotWidth:0]       mag_sum;
    logic [QuotWidth:0]       mag_plain;
    logic [QuotWidth:0]       mag;
    logic signed [15:0]       sat;

    always_comb begin
        cur_d     = r_axis ? r_dy : r_dx;
        cur_m     = cur_d[MagWidth] ? 10'(-cur_d) : 10'(cur_d);
        cur_acc   = cur_m > {2'b0, r_thr};
        m_minus_t = cur_m - {2'b0, r_thr};
        prod      = ProdWidth'(m_minus_t[MagWidth-1:0] * r_num);
        den_eff   = (r_den == 8'd0) ? 8'd1 : r_den;
        trial     = {r_rem[7:0], r_rem_src[ProdWidth-1]};
        mag_sum   = {1'b0, r_quo} + {10'd0, r_thr};
        mag_plain = {8'd0, cur_m};
        mag       = cur_acc ? mag_sum : mag_plain;
        if (cur_d[MagWidth]) begin
            sat = (mag > 18'd32768) ? 16'sh8000 : 16'(-mag);
        end else begin
            sat = (mag > 18'd32767) ? 16'sh7FFF : 16'(mag);
        end
    end

    always_comb begin
        logic [7:0]  b0, b1, b2;
        logic        hdr_ok, dp_bad;
        logic [2:0]  f;
        logic [2:0]  m3;
        b0 = r_pkt[0];
        b1 = r_pkt[1];
        b2 = r_pkt[2];
        n_state = r_state;
        n_fill = r_fill;
        n_last = r_last;
        n_dx = r_dx; n_dy = r_dy; n_dz = r_dz; n_btn = r_btn;
        n_axis = r_axis; n_cnt = r_cnt;
        n_rem_src = r_rem_src; n_rem = r_rem; n_quo = r_quo;
        n_mx = r_mx; n_my = r_my; n_chg = r_chg;
        n_ovalid = r_ovalid && !res.ready;
        wr_en = 1'b0;
        wr_idx = '0;
        hdr_ok = (b & p.hd_mask) == p.hd_id;
        dp_bad = ((b & p.dp_mask) != p.dp_id) || (b == 8'h80);
        f = r_fill;
        m3 = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept && r_type < 4'(NumTypes)) begin
                    if (f != 3'd0 && dp_bad) f = 3'd0;
                    if (f == 3'd0 && !hdr_ok) begin
                        n_fill = 3'd0;
                    end else if (f >= p.len && !hdr_ok) begin
                        n_fill = 3'd0;
                        if ((b & p.b4_mask) == p.b4_id) begin
                            n_dx = '0; n_dy = '0; n_dz = '0;
                            if (r_type == TypeImserial) begin
                                n_dz  = b[3:0];
                                n_btn = {3'b0, b[5], r_last[2], b[4], 1'b0}
                                        | {6'b0, r_last[0]};
                            end else begin
                                n_btn = {3'b0,
                                         ((r_type == TypeGlide) || (r_type == TypeThinking))
                                             & b[4],
                                         r_last[2], b[5], r_last[0]};
                            end
                            n_axis = 1'b0;
                            n_state = ST_NEXT;
                        end
                    end else begin
                        if (f >= p.len) f = 3'd0;
                        wr_en  = 1'b1;
                        wr_idx = f;
                        n_fill = f + 3'd1;
                        if (f + 3'd1 == p.len) begin
                            n_state = ST_DONE;
                        end
                    end
                end
            end
            ST_DONE: begin
                // packet complete: decode from stored bytes
                n_dz = '0;
                case (r_type)
                    TypeMs, TypeLogiman: begin
                        if (r_chord && b0[5:4] == 2'b11) n_btn = 7'd2;
                        else n_btn = {4'b0, b0[5], r_chord ? 1'b0 : r_last[1], b0[4]};
                        n_dx = sx8({b0[1:0], b1[5:0]});
                        n_dy = sx8({b0[3:2], b2[5:0]});
                    end
                    TypeGlide, TypeImserial, TypeThinking: begin
                        n_btn = {3'b0, r_last[3], b0[5], r_last[1], b0[4]};
                        n_dx = sx8({b0[1:0], b1[5:0]});
                        n_dy = sx8({b0[3:2], b2[5:0]});
                    end
                    TypeMsc: begin
                        n_btn = {4'b0, ~b0[2:0]};
                        n_dx = sx8(b1) + sx8(r_pkt[3]);
                        n_dy = -(sx8(b2) + sx8(r_pkt[4]));
                    end
                    default: begin
                        m3 = b0[2:0];
                        if (r_type == TypeMmhit && m3 != 3'd0)
                            n_btn = 7'd1 << (m3 - 3'd1);
                        else
                            n_btn = {4'b0, m3};
                        n_dx = b0[4] ? $signed({2'b0, b1}) : -$signed({2'b0, b1});
                        n_dy = b0[3] ? -$signed({2'b0, b2}) : $signed({2'b0, b2});
                    end
                endcase
                n_axis = 1'b0;
                n_state = ST_NEXT;
            end
            ST_NEXT: begin
                n_rem_src = prod;
                n_rem = '0;
                n_quo = '0;
                n_cnt = 5'(DivCount);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt != 5'd0) begin
                    // one restoring step per cycle
                    n_rem_src = {r_rem_src[ProdWidth-2:0], 1'b0};
                    if (trial >= {1'b0, den_eff}) begin
                        n_rem = trial - {1'b0, den_eff};
                        n_quo = {r_quo[QuotWidth-2:0], 1'b1};
                    end else begin
                        n_rem = trial;
                        n_quo = {r_quo[QuotWidth-2:0], 1'b0};
                    end
                    n_cnt = r_cnt - 5'd1;
                end else begin
                    if (!r_axis) begin
                        n_mx = sat;
                        n_axis = 1'b1;
                        n_state = ST_NEXT;
                    end else begin
                        n_my = sat;
                        n_state = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                n_chg = (r_last[2:0] ^ r_btn[2:0]);
                n_last = r_btn;
                n_ovalid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_last   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= n_dx; r_dy <= n_dy; r_dz <= n_dz; r_btn <= n_btn;
        r_axis <= n_axis; r_cnt <= n_cnt;
        r_rem_src <= n_rem_src; r_rem <= n_rem; r_quo <= n_quo;
        r_mx <= n_mx; r_my <= n_my; r_chg <= n_chg;
    end

    assign res.valid          = r_ovalid;
    assign res.move_x         = r_mx;
    assign res.move_y         = r_my;
    assign res.wheel          = r_dz;
    assign res.button_state   = r_last;
    assign res.button_changed = r_chg;

endmodule

/* rtl/smpd_checker.sv */
module smpd_assertions
    import smpd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        rx_valid,
    input logic        rx_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [6:0]  res_button_state,
    input logic [2:0]  res_button_changed,
    input logic signed [3:0] res_wheel
);

    // No new byte is taken while a result beat waits.
    a_no_rx_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !rx_ready) else $error("byte taken while result pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_button_state)
            && $stable(res_button_changed) && $stable(res_wheel))
        else $error("stalled result changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !res_valid) else $error("result after reset");

    a_rx_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(res_valid) |-> !$past(rx_ready)) else $error("result without work");

    // A result never appears in the cycle right after a byte beat.
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_valid && rx_ready |=> !res_valid) else $error("result too early");

endmodule

bind serial_mouse_packet_decoder_top smpd_assertions u_smpd_assertions (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .rx_valid           (rx.valid),
    .rx_ready           (rx.ready),
    .res_valid          (res.valid),
    .res_ready          (res.ready),
    .res_button_state   (res.button_state),
    .res_button_changed (res.button_changed),
    .res_wheel          (res.wheel)
);

/* sim/smpd_checker.sv */
module smpd_checker
    import smpd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [CfgDataWidth-1:0] i_cfg_data,
    smpd_rx_if                      rx,
    smpd_res_if                     res,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct {
        logic [15:0] move_x;
        logic [15:0] move_y;
        logic [3:0]  wheel;
        logic [6:0]  button_state;
        logic [2:0]  button_changed;
    } t_motion;

    t_motion motion_q[$];

    logic [3:0] cur_type;
    logic       cur_chord;
    logic [7:0] cur_thr;
    logic [7:0] cur_num;
    logic [7:0] cur_den;
    int         fill;
    logic [7:0] pkt[5];
    logic [6:0] prev_buttons;

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    function automatic logic [15:0] accel_axis(input int d);
        int m;
        int r;
        int den;
        m = (d < 0) ? -d : d;
        den = (cur_den == 0) ? 1 : int'(cur_den);
        r = m;
        if (m > int'(cur_thr))
            r = int'(cur_thr) + ((m - int'(cur_thr)) * int'(cur_num)) / den;
        if (d < 0) begin
            r = -r;
            if (r < -32768) r = -32768;
        end else if (r > 32767) begin
            r = 32767;
        end
        return r[15:0];
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        logic [7:0] hmask, hid, dmask, did, b4m, b4i;
        int         plen;
        logic [6:0] btn;
        int         dx, dy;
        logic [3:0] dz;
        logic [7:0] b0, b1, b2;
        t_motion    m;
        btn = '0;
        dx = 0;
        dy = 0;
        dz = '0;
        if (cur_type >= NumTypes) return;
        case (cur_type)
            TypeMsc: begin
                hmask = 8'hF8; hid = 8'h80; dmask = 8'h00; did = 8'h00;
                plen = 5; b4m = 8'h00; b4i = 8'hFF;
            end
            TypeMm, TypeLogi, TypeMmhit: begin
                hmask = 8'hE0; hid = 8'h80; dmask = 8'h80; did = 8'h00;
                plen = 3; b4m = 8'h00; b4i = 8'hFF;
            end
            default: begin
                hmask = 8'h40; hid = 8'h40; dmask = 8'h40; did = 8'h00;
                plen = 3; b4i = 8'h00;
                if (cur_type == TypeImserial) b4m = 8'hC0;
                else if (cur_type == TypeGlide || cur_type == TypeThinking) b4m = 8'hCC;
                else b4m = 8'hDC;
            end
        endcase

        if (fill != 0 && ((b & dmask) != did || b == 8'h80)) fill = 0;
        if (fill == 0 && (b & hmask) != hid) return;

        if (fill >= plen && (b & hmask) != hid) begin
            // Optional trailing byte after a complete packet.
            if ((b & b4m) != b4i) begin
                fill = 0;
                return;
            end
            if (cur_type == TypeImserial) begin
                dz = b[3:0];
                btn = {3'b000, b[5], 1'b0, b[4], 1'b0} | (prev_buttons & 7'h05);
            end else begin
                if (cur_type == TypeGlide || cur_type == TypeThinking) btn[3] = b[4];
                btn = btn | {5'b0, b[5], 1'b0} | (prev_buttons & 7'h05);
            end
            fill = 0;
        end else begin
            if (fill >= plen) fill = 0;
            pkt[fill % 5] = b;
            fill++;
            if (fill != plen) return;
            b0 = pkt[0];
            b1 = pkt[1];
            b2 = pkt[2];
            case (cur_type)
                TypeMs, TypeLogiman, TypeGlide, TypeImserial, TypeThinking: begin
                    if ((cur_type == TypeMs || cur_type == TypeLogiman) && cur_chord
                        && b0[5:4] == 2'b11)
                        btn = 7'd2;
                    else if (cur_type == TypeMs || cur_type == TypeLogiman)
                        btn = (cur_chord ? 7'd0 : (prev_buttons & 7'd2))
                            | {4'b0, b0[5], 1'b0, b0[4]};
                    else
                        btn = (prev_buttons & 7'd10) | {4'b0, b0[5], 1'b0, b0[4]};
                    dx = int'($signed({b0[1:0], b1[5:0]}));
                    dy = int'($signed({b0[3:2], b2[5:0]}));
                end
                TypeMsc: begin
                    btn = {4'b0, ~b0[2:0]};
                    dx = int'($signed(b1)) + int'($signed(pkt[3]));
                    dy = -(int'($signed(b2)) + int'($signed(pkt[4])));
                end
                default: begin
                    btn = {4'b0, b0[2:0]};
                    if (cur_type == TypeMmhit && btn != 0) btn = 7'd1 << (btn - 1);
                    dx = b0[4] ? int'(b1) : -int'(b1);
                    dy = b0[3] ? -int'(b2) : int'(b2);
                end
            endcase
        end

        m.move_x = accel_axis(dx);
        m.move_y = accel_axis(dy);
        m.wheel = dz;
        m.button_state = btn;
        m.button_changed = prev_buttons[2:0] ^ btn[2:0];
        prev_buttons = btn;
        motion_q.push_back(m);
    endtask

    initial o_fail_count = 0;
    initial o_pending = 0;

    always @(posedge i_clk) begin
        t_motion want;
        if (!i_rst_n) begin
            cur_type = TypeMs;
            cur_chord = 1'b0;
            cur_thr = 8'd4;
            cur_num = 8'd2;
            cur_den = 8'd1;
            fill = 0;
            for (int i = 0; i < 5; i++) pkt[i] = '0;
            prev_buttons = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgMouseType:   cur_type = i_cfg_data[3:0];
                    CfgChord:       cur_chord = i_cfg_data[0];
                    CfgThreshold:   cur_thr = i_cfg_data;
                    CfgNumerator:   cur_num = i_cfg_data;
                    CfgDenominator: cur_den = i_cfg_data;
                    default: ;
                endcase
            end
            if (res.valid && res.ready) begin
                if (motion_q.size() == 0) begin
                    report("unexpected beat", '0, '0);
                end else begin
                    want = motion_q.pop_front();
                    if (res.move_x !== want.move_x) report("move_x", res.move_x, want.move_x);
                    if (res.move_y !== want.move_y) report("move_y", res.move_y, want.move_y);
                    if (res.wheel !== want.wheel) report("wheel", res.wheel, want.wheel);
                    if (res.button_state !== want.button_state)
                        report("button_state", res.button_state, want.button_state);
                    if (res.button_changed !== want.button_changed)
                        report("button_changed", res.button_changed, want.button_changed);
                end
            end
            if (rx.valid && rx.ready) decode_byte(rx.rx_byte);
        end
        o_pending = motion_q.size();
    end

endmodule

/* sim/testbench.sv */
module testbench;
    import smpd_pkg::*;

    localparam int IdleLimit = 3000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we;
    logic [CfgIdxWidth-1:0]  cfg_idx;
    logic [CfgDataWidth-1:0] cfg_data;
    int                      fail_count;
    int                      pending;
    int                      idle_cycles = 0;
    int                      stall_left = 0;
    bit                      steady_phase = 1'b0;
    int                      bytes_sent = 0;

    smpd_rx_if  rx ();
    smpd_res_if res ();

    serial_mouse_packet_decoder_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .rx         (rx),
        .res        (res)
    );

    smpd_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .rx           (rx),
        .res          (res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    // Outside the steady phases the result sink stalls at random before each beat.
    always @(posedge clk) begin
        if (res.valid && res.ready)
            stall_left = steady_phase ? 0 : $urandom_range(0, 19);
        res.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
    end

    always @(posedge clk) begin
        if ((rx.valid && rx.ready) || (res.valid && res.ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
            $display("[serial_mouse_packet_decoder_top] ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = steady_phase ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            rx.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx.valid <= 1'b1;
        rx.rx_byte <= b;
        do @(posedge clk); while (!rx.ready);
        bytes_sent++;
    endtask

    // Drop valid right away so the last byte is not taken twice, then wait
    // until every predicted beat has left the block.
    task automatic settle();
        rx.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [7:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One well-formed packet of the current protocol, sometimes with a trailing byte.
    task automatic send_packet(input logic [3:0] mt);
        logic [7:0] b;
        int         plen;
        plen = (mt == TypeMsc) ? 5 : 3;
        for (int i = 0; i < plen; i++) begin
            b = 8'($urandom);
            if (mt == TypeMsc) begin
                if (i == 0) b = {5'b10000, b[2:0]};
                else if (b == 8'h80) b = 8'h7F;
            end else if (mt == TypeMm || mt == TypeLogi || mt == TypeMmhit) begin
                b = (i == 0) ? {3'b100, b[4:0]} : {1'b0, b[6:0]};
            end else begin
                b[6] = (i == 0);
            end
            send_byte(b);
        end
        if ($urandom_range(0, 2) == 0) begin
            b = 8'($urandom);
            case (mt)
                TypeMs, TypeLogiman:     b = b & 8'h23;
                TypeGlide, TypeThinking: b = b & 8'h33;
                TypeImserial:            b = b & 8'h3F;
                default:                 ;
            endcase
            send_byte(b);
        end
    endtask

    initial begin
        logic [3:0] mt;
        logic [7:0] thr, num, den;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        rx.valid = 1'b0;
        rx.rx_byte = '0;
        res.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: chorded buttons, largest deltas, trailing byte, resync mid-packet.
        write_reg(CfgChord, 8'd1);
        send_byte(8'h7F); send_byte(8'h3F); send_byte(8'h3F);
        send_byte(8'h23);
        send_byte(8'h40); send_byte(8'h80); send_byte(8'h00);
        send_byte(8'h4A); send_byte(8'h00); send_byte(8'h20);
        send_byte(8'hFF); send_byte(8'h00);
        settle();
        write_reg(CfgThreshold, 8'd0);
        write_reg(CfgNumerator, 8'd255);
        write_reg(CfgDenominator, 8'd0);
        write_reg(CfgMouseType, {4'b0, TypeMsc});
        send_byte(8'h80); send_byte(8'h80); send_byte(8'h7F);
        send_byte(8'h80); send_byte(8'h81); send_byte(8'h80); send_byte(8'h80);
        send_byte(8'h80);
        settle();
        write_reg(CfgMouseType, {4'b0, TypeMmhit});
        send_byte(8'h9F); send_byte(8'h7F); send_byte(8'h7F);
        settle();

        for (int ph = 0; ph < 32; ph++) begin
            mt = (ph % 11 == 10) ? 4'($urandom_range(9, 15)) : 4'(ph % 9);
            case (ph % 4)
                0: begin thr = 8'd0;   num = 8'd255; den = 8'd1; end
                1: begin thr = 8'd255; num = 8'd1;   den = 8'd255; end
                2: begin
                    thr = 8'($urandom);
                    num = 8'($urandom_range(1, 255));
                    den = 8'd0;
                end
                default: begin
                    thr = 8'($urandom_range(0, 20));
                    num = 8'($urandom_range(1, 255));
                    den = 8'($urandom_range(1, 255));
                end
            endcase
            write_reg(CfgMouseType, {4'b0, mt});
            write_reg(CfgChord, 8'($urandom_range(0, 1)));
            write_reg(CfgThreshold, thr);
            write_reg(CfgNumerator, num);
            write_reg(CfgDenominator, den);
            steady_phase = (ph % 5 == 3);
            bytes_sent = 0;
            while (bytes_sent < 32) begin
                if ($urandom_range(0, 9) < 8) send_packet(mt);
                else send_byte(8'($urandom));
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("[serial_mouse_packet_decoder_top] OK");
        end else begin
            $display("[serial_mouse_packet_decoder_top] ERROR");
        end
        $finish;
    end

endmodule

/* serial_mouse_packet_decoder_top.f */
rtl/smpd_pkg.sv
rtl/smpd_rx_if.sv
rtl/smpd_res_if.sv
rtl/serial_mouse_packet_decoder_top.sv
rtl/smpd_checker.sv
sim/smpd_checker.sv
sim/testbench.sv
